// ===== hw/rtl/vtpg_pkg.sv =====
package vtpg_pkg;

    // pattern codes as held in the mode register
    typedef enum logic [1:0] {
        PAT_CHECKER = 2'd0,
        PAT_BACK    = 2'd1,
        PAT_FORE    = 2'd2,
        PAT_RETICLE = 2'd3
    } t_pattern_mode;

    // configuration register indexes
    localparam logic [2:0] CFG_PATTERN_MODE  = 3'd0;
    localparam logic [2:0] CFG_FORE_COLOR    = 3'd1;
    localparam logic [2:0] CFG_BACK_COLOR    = 3'd2;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_SIDE_X        = 3'd5;
    localparam logic [2:0] CFG_SIDE_Y        = 3'd6;
    localparam logic [2:0] CFG_BORDER_ENABLE = 3'd7;

    // register field widths
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int DIM_CFG_W   = 13;
    localparam int COLOR_W     = 24;

    // reset values
    localparam logic [23:0] FORE_RESET   = 24'hFFFFFF;
    localparam logic [23:0] BACK_RESET   = 24'h000000;
    localparam logic [12:0] WIDTH_RESET  = 13'd576;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [12:0] SIDE_RESET   = 13'd32;

    // fixed reticle line positions
    localparam int RET_COL = 288;
    localparam int RET_ROW = 240;

    // raster status for the current pixel
    typedef struct packed {
        logic eol;
        logic eof;
        logic row_par;
        logic col_par;
    } t_raster_stat;

endpackage

// ===== hw/rtl/video_test_pattern_generator.sv =====
// channel   dir  tdata                      tlast        tuser
// s_axis    in   [0] restart                -            -
// m_axis    out  [7:0] red [15:8] green     end_of_line  end_of_frame
//                [23:16] blue
// cfg       in   write enable, index, data (no read-back)
//
// one pixel per clock sustained while the output is not stalled; a word passes
// through the input register and then through the pattern logic to the output
// register, and the raster counters update on each word that moves on.
// synchronous active-low reset clears the counters, the stage valids and the
// registers to their defaults. a stalled output holds its word; the input
// register still takes a new word whenever the output register frees up.
module video_test_pattern_generator #(
    parameter int MAX_DIM_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [0] restart
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata,  // red, green, blue
    output logic                           o_m_axis_tlast,  // end_of_line
    output logic                           o_m_axis_tuser,  // end_of_frame
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [vtpg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vtpg_pkg::*;

    localparam int DW = MAX_DIM_BITS + 1;
    localparam int CW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
    localparam logic [CW-1:0] DIM_MAX = CW'(1) << MAX_DIM_BITS;

    // configuration registers
    t_pattern_mode  r_mode;
    logic [23:0]    r_fore, r_back;
    logic [12:0]    r_width, r_height, r_side_x, r_side_y;
    logic           r_border;

    // pipeline registers
    logic           r_in_valid, r_in_restart;
    logic           r_out_valid, r_out_last, r_out_user;
    logic [23:0]    r_out_data;

    logic           fire;
    logic [DW-1:0]  w, h, sx, sy;
    logic [MAX_DIM_BITS-1:0] row, col;
    t_raster_stat   stat;
    logic [23:0]    color;

    function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        if (x == '0) begin
            return DW'(1);
        end else if (x > DIM_MAX) begin
            return DIM_MAX[DW-1:0];
        end else begin
            return x[DW-1:0];
        end
    endfunction

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= PAT_CHECKER;
            r_fore   <= FORE_RESET;
            r_back   <= BACK_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_side_x <= SIDE_RESET;
            r_side_y <= SIDE_RESET;
            r_border <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PATTERN_MODE:  r_mode   <= t_pattern_mode'(i_cfg_data[1:0]);
                CFG_FORE_COLOR:    r_fore   <= i_cfg_data[23:0];
                CFG_BACK_COLOR:    r_back   <= i_cfg_data[23:0];
                CFG_FRAME_WIDTH:   r_width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT:  r_height <= i_cfg_data[12:0];
                CFG_SIDE_X:        r_side_x <= i_cfg_data[12:0];
                CFG_SIDE_Y:        r_side_y <= i_cfg_data[12:0];
                CFG_BORDER_ENABLE: r_border <= i_cfg_data[0];
                default:           r_border <= r_border;
            endcase
        end
    end

    // dimensions held inside 1 .. 2^MAX_DIM_BITS
    assign w  = clamp_dim(r_width);
    assign h  = clamp_dim(r_height);
    assign sx = clamp_dim(r_side_x);
    assign sy = clamp_dim(r_side_y);

    // handshake
    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_restart <= i_s_axis_tdata[0];
        end
    end

    vtpg_raster #(
        .MAX_DIM_BITS(MAX_DIM_BITS)
    ) u_raster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (fire),
        .i_restart (r_in_restart),
        .i_width   (w),
        .i_height  (h),
        .i_side_x  (sx),
        .i_side_y  (sy),
        .o_row     (row),
        .o_col     (col),
        .o_stat    (stat)
    );

    vtpg_pixel #(
        .MAX_DIM_BITS(MAX_DIM_BITS)
    ) u_pixel (
        .i_mode   (r_mode),
        .i_fore   (r_fore),
        .i_back   (r_back),
        .i_border (r_border),
        .i_width  (w),
        .i_height (h),
        .i_side_x (sx),
        .i_side_y (sy),
        .i_row    (row),
        .i_col    (col),
        .i_stat   (stat),
        .o_color  (color)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {color[7:0], color[15:8], color[23:16]};
            r_out_last <= stat.eol;
            r_out_user <= stat.eof;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

    // a frame end is always also a line end
    a_eof_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser || o_m_axis_tlast))
        else $error("end of frame without end of line");

    // a held input word blocks new input
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |-> !o_s_axis_tready)
        else $error("input register overwritten");

    // a processed word shows up at the output
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_axis_tvalid)
        else $error("processed word lost");

endmodule

// ===== hw/rtl/vtpg_raster.sv =====
module vtpg_raster #(
    parameter int MAX_DIM_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_restart,
    input  logic [MAX_DIM_BITS:0]     i_width,
    input  logic [MAX_DIM_BITS:0]     i_height,
    input  logic [MAX_DIM_BITS:0]     i_side_x,
    input  logic [MAX_DIM_BITS:0]     i_side_y,
    output logic [MAX_DIM_BITS-1:0]   o_row,
    output logic [MAX_DIM_BITS-1:0]   o_col,
    output vtpg_pkg::t_raster_stat    o_stat
);
    import vtpg_pkg::*;

    localparam int DW = MAX_DIM_BITS + 1;

    logic [MAX_DIM_BITS-1:0] r_row, r_col, r_row_ph, r_col_ph;
    logic                    r_row_par, r_col_par;
    logic [MAX_DIM_BITS-1:0] n_row, n_col, n_row_ph, n_col_ph;
    logic                    n_row_par, n_col_par;

    logic [MAX_DIM_BITS-1:0] e_row, e_col, e_row_ph, e_col_ph;
    logic                    e_row_par, e_col_par;
    logic                    eol, eof;
    logic [DW-1:0]           row_ph_inc, col_ph_inc;

    // restart puts this pixel at the frame origin
    always_comb begin
        e_row     = i_restart ? '0 : r_row;
        e_col     = i_restart ? '0 : r_col;
        e_row_ph  = i_restart ? '0 : r_row_ph;
        e_col_ph  = i_restart ? '0 : r_col_ph;
        e_row_par = i_restart ? 1'b0 : r_row_par;
        e_col_par = i_restart ? 1'b0 : r_col_par;
    end

    // line and frame end, a counter past the last position counts as on it
    assign eol = {1'b0, e_col} >= (i_width - DW'(1));
    assign eof = eol && ({1'b0, e_row} >= (i_height - DW'(1)));

    assign row_ph_inc = {1'b0, e_row_ph} + DW'(1);
    assign col_ph_inc = {1'b0, e_col_ph} + DW'(1);

    // raster advance
    always_comb begin
        n_row     = e_row;
        n_col     = e_col;
        n_row_ph  = e_row_ph;
        n_col_ph  = e_col_ph;
        n_row_par = e_row_par;
        n_col_par = e_col_par;
        if (eol) begin
            n_col     = '0;
            n_col_ph  = '0;
            n_col_par = 1'b0;
            if (eof) begin
                n_row     = '0;
                n_row_ph  = '0;
                n_row_par = 1'b0;
            end else begin
                n_row = e_row + MAX_DIM_BITS'(1);
                if (row_ph_inc >= i_side_y) begin
                    n_row_ph  = '0;
                    n_row_par = ~e_row_par;
                end else begin
                    n_row_ph = row_ph_inc[MAX_DIM_BITS-1:0];
                end
            end
        end else begin
            n_col = e_col + MAX_DIM_BITS'(1);
            if (col_ph_inc >= i_side_x) begin
                n_col_ph  = '0;
                n_col_par = ~e_col_par;
            end else begin
                n_col_ph = col_ph_inc[MAX_DIM_BITS-1:0];
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_row_ph  <= '0;
            r_col_ph  <= '0;
            r_row_par <= 1'b0;
            r_col_par <= 1'b0;
        end else if (i_step) begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_row_ph  <= n_row_ph;
            r_col_ph  <= n_col_ph;
            r_row_par <= n_row_par;
            r_col_par <= n_col_par;
        end
    end

    assign o_row          = e_row;
    assign o_col          = e_col;
    assign o_stat.eol     = eol;
    assign o_stat.eof     = eof;
    assign o_stat.row_par = e_row_par;
    assign o_stat.col_par = e_col_par;

endmodule

// ===== hw/rtl/vtpg_pixel.sv =====
module vtpg_pixel #(
    parameter int MAX_DIM_BITS = 12
) (
    input  vtpg_pkg::t_pattern_mode   i_mode,
    input  logic [23:0]               i_fore,
    input  logic [23:0]               i_back,
    input  logic                      i_border,
    input  logic [MAX_DIM_BITS:0]     i_width,
    input  logic [MAX_DIM_BITS:0]     i_height,
    input  logic [MAX_DIM_BITS:0]     i_side_x,
    input  logic [MAX_DIM_BITS:0]     i_side_y,
    input  logic [MAX_DIM_BITS-1:0]   i_row,
    input  logic [MAX_DIM_BITS-1:0]   i_col,
    input  vtpg_pkg::t_raster_stat    i_stat,
    output logic [23:0]               o_color
);
    import vtpg_pkg::*;

    localparam int DW = MAX_DIM_BITS + 1;

    logic [DW-1:0] colx, rowx, w_last, h_last;
    logic          on_border, on_line, fore;

    assign colx   = {1'b0, i_col};
    assign rowx   = {1'b0, i_row};
    assign w_last = i_width - DW'(1);
    assign h_last = i_height - DW'(1);

    // one-pixel frame border
    assign on_border = i_border &&
        (colx == '0 || colx == w_last || rowx == '0 || rowx == h_last);

    // reticle lines, each skipped when it falls outside the frame
    assign on_line =
        (i_side_y < i_width && colx == i_side_y) ||
        (i_side_y <= i_width && colx == i_width - i_side_y) ||
        (32'(RET_COL) < 32'(i_width) && 32'(colx) == 32'(RET_COL)) ||
        (i_side_x < i_height && rowx == i_side_x) ||
        (i_side_x <= i_height && rowx == i_height - i_side_x) ||
        (32'(RET_ROW) < 32'(i_height) && 32'(rowx) == 32'(RET_ROW));

    // pattern select
    always_comb begin
        unique case (i_mode)
            PAT_CHECKER: fore = (i_stat.row_par == i_stat.col_par) || on_border;
            PAT_BACK:    fore = 1'b0;
            PAT_FORE:    fore = 1'b1;
            PAT_RETICLE: fore = (i_border && on_line) || on_border;
            default:     fore = 1'b0;
        endcase
    end

    assign o_color = fore ? i_fore : i_back;

endmodule
